// ----- hw/rtl/sos_pkg.sv -----
// Shared types, constants and helper functions of the sum-over-states tensor unit.
package sos_pkg;

  // Field widths
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned CFG_W    = 31;
  localparam int unsigned ACC_W    = 64;
  localparam int unsigned ENTRY_W  = 6;

  // Reciprocal datapath widths
  localparam int unsigned HALF_W   = 32;   // |E -/+ w|
  localparam int unsigned NUM_W    = 33;   // divider numerator
  localparam int unsigned DEN_W    = 67;   // x^2 + y^2
  localparam int unsigned Q_W      = 54;   // quotient bits
  localparam int unsigned DIV_STEPS = 54;
  localparam int unsigned R_W      = 55;   // signed reciprocal part
  localparam int unsigned SUM_W    = 56;   // signed sum or difference
  localparam int unsigned S_W      = 55;   // magnitude of sum or difference

  // Scaling multiplier widths
  localparam int unsigned P_W      = 63;   // dipole product magnitude
  localparam int unsigned W_W      = 118;  // full scaled product

  localparam int unsigned NUM_ENTRIES = 36;

  // Register indexes
  localparam logic REG_PROBE = 1'b0;
  localparam logic REG_DAMP  = 1'b1;

  // Item modes
  localparam logic MODE_ACC  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Tensor kinds
  localparam logic [1:0] KIND_EE = 2'd0;
  localparam logic [1:0] KIND_MM = 2'd1;
  localparam logic [1:0] KIND_EM = 2'd2;
  localparam logic [1:0] KIND_ME = 2'd3;

  // Sum and difference slots
  localparam logic [1:0] SLOT_SR = 2'd0;
  localparam logic [1:0] SLOT_SI = 2'd1;
  localparam logic [1:0] SLOT_DR = 2'd2;
  localparam logic [1:0] SLOT_DI = 2'd3;

  localparam logic signed [R_W-1:0] RECIP_SAT = R_W'(64'd1 << 53);

  typedef struct packed {
    logic                      mode;
    logic signed [FIELD_W-1:0] energy;
    logic signed [FIELD_W-1:0] el_x;
    logic signed [FIELD_W-1:0] el_y;
    logic signed [FIELD_W-1:0] el_z;
    logic signed [FIELD_W-1:0] mag_x;
    logic signed [FIELD_W-1:0] mag_y;
    logic signed [FIELD_W-1:0] mag_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              tensor_kind;
    logic [1:0]              row;
    logic [1:0]              column;
    logic signed [ACC_W-1:0] real_part;
    logic signed [ACC_W-1:0] imag_part;
    logic                    last;
  } out_item_t;

  // Divider lane controls
  typedef struct packed {
    logic load;
    logic step;
  } sos_div_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_SQR,
    ST_DEN,
    ST_DIV,
    ST_FIN1,
    ST_FIN2,
    ST_ACC,
    ST_DRAIN,
    ST_RD_ADDR,
    ST_RD_DATA
  } sos_state_e;

  // Flat entry number kind*9 + row*3 + column.
  function automatic logic [ENTRY_W-1:0] entry_index(input logic [1:0] kind,
                                                     input logic [1:0] row,
                                                     input logic [1:0] col);
    logic [ENTRY_W-1:0] k9;
    logic [ENTRY_W-1:0] r3;
    k9 = {1'b0, kind, 3'b000} + {4'b0000, kind};
    r3 = {3'b000, row, 1'b0} + {4'b0000, row};
    return k9 + r3 + {4'b0000, col};
  endfunction

  // Signed add that clamps to the 64-bit range.
  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] sum;
    sum = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      return sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return sum[ACC_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/sos_recip_div.sv -----
// One radix-2 restoring divider lane producing num*2^53/den.
module sos_recip_div import sos_pkg::*; (
  input  logic                 clk_i,
  input  sos_div_ctrl_t        ctrl_i,
  input  logic [NUM_W-1:0]     num_i,
  input  logic [DEN_W-1:0]     den_i,
  output logic [Q_W-1:0]       quot_o
);

  logic [DEN_W-1:0] rem_q;
  logic             nb_q;
  logic [Q_W-1:0]   quot_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Shift in the next numerator bit and try a subtraction.
  assign trial = {rem_q, nb_q};
  assign diff  = trial - {1'b0, den_i};
  assign ge    = trial >= {1'b0, den_i};

  // The numerator is shifted left by 53, so only its lowest bit enters after the start value.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rem_q  <= {{(DEN_W-NUM_W+1){1'b0}}, num_i[NUM_W-1:1]};
      nb_q   <= num_i[0];
      quot_q <= '0;
    end else if (ctrl_i.step) begin
      rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      nb_q   <= 1'b0;
      quot_q <= {quot_q[Q_W-2:0], ge};
    end
  end

  assign quot_o = quot_q;

endmodule

// ----- hw/rtl/sum_over_states_response_tensor_unit.sv -----
// Top level of the damped sum-over-states response tensor accumulator.
//
// An accumulate transaction (mode 0) runs the setup states PREP, SQR and DEN, then four
// parallel radix-2 dividers form both complex reciprocals, FIN1 and FIN2 combine them, and
// in ACC one shared pipelined scaling multiplier feeds one accumulator update per cycle
// (real and imaginary parts alternate), followed by a drain. A readout transaction (mode 1)
// delivers 36 entries, each through RD_ADDR and RD_DATA, waiting while the output is stalled,
// and clears the sums. The input is stalled while a transaction is in progress. The sums
// live in two 36-entry memories with a registered read; per-entry valid bits make an
// entry that was never written, or was cleared by a readout, read as zero.
module sum_over_states_response_tensor_unit import sos_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sos_state_e state_q, state_d;

  // Configuration registers
  logic [CFG_W-1:0] probe_q, damp_q;

  // Captured item
  logic signed [FIELD_W-1:0] energy_q;
  logic signed [FIELD_W-1:0] el_raw_q [3];
  logic signed [FIELD_W-1:0] mg_raw_q [3];
  logic [FIELD_W-1:0]        el_mag_q [3];
  logic [FIELD_W-1:0]        mg_mag_q [3];
  logic                      el_neg_q [3];
  logic                      mg_neg_q [3];

  // Reciprocal setup
  logic [HALF_W-1:0]   h1_q, h2_q;
  logic                x1_neg_q, x2_neg_q;
  logic [2*HALF_W-1:0] sq1_q, sq2_q;
  logic [2*CFG_W-1:0]  gg_q;
  logic [DEN_W-1:0]    den1_q, den2_q;
  logic                zero1_q, zero2_q;
  logic [5:0]          div_cnt_q;
  sos_div_ctrl_t       div_ctrl;
  logic [Q_W-1:0]      quot [4];
  logic signed [R_W-1:0] r1r_q, r1i_q, r2r_q, r2i_q;
  logic [S_W-1:0]      s_mag_q [4];
  logic                s_neg_q [4];

  // Entry counters
  logic [1:0] kind_q, row_q, col_q;
  logic       part_q;
  logic [1:0] kind_d, row_d, col_d;
  logic       part_d;
  logic       adv;
  logic       acc_issue;
  logic       acc_last;
  logic       rd_load;
  logic       rd_last;
  logic [ENTRY_W-1:0] k_cnt;

  // Scaling pipeline
  logic                s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic [P_W-1:0]      s1_p_q;
  logic [S_W-1:0]      s1_s_q;
  logic                s1_neg_q, s2_neg_q, s3_neg_q;
  logic [ENTRY_W-1:0]  s1_k_q, s2_k_q, s3_k_q, s4_k_q;
  logic                s1_part_q, s2_part_q, s3_part_q, s4_part_q;
  logic [59:0]         pp00_q;
  logic [58:0]         pp01_q, pp10_q;
  logic [57:0]         pp11_q;
  logic [W_W-1:0]      s3_w_q;
  logic signed [ACC_W-1:0] s4_val_q;

  // Accumulator memories
  logic signed [ACC_W-1:0] acc_re_mem [NUM_ENTRIES];
  logic signed [ACC_W-1:0] acc_im_mem [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0]  vld_re_q, vld_im_q;
  logic [ENTRY_W-1:0]      rd_addr;
  logic signed [ACC_W-1:0] rd_re_q, rd_im_q;
  logic                    rd_vre_q, rd_vim_q;

  // Output register
  out_item_t out_q;
  logic      out_valid_q;

  logic accept;
  logic cfg_wr;

  assign accept = in_valid_i && !in_stall_o;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Configuration port
  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      REG_PROBE: prdata = {1'b0, probe_q};
      REG_DAMP:  prdata = {1'b0, damp_q};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
      damp_q  <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_PROBE: probe_q <= pwdata[CFG_W-1:0];
        REG_DAMP:  damp_q  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign k_cnt    = entry_index(kind_q, row_q, col_q);
  assign acc_last = (kind_q == KIND_ME) && (row_q == 2'd2) && (col_q == 2'd2) && part_q;
  assign rd_last  = (kind_q == KIND_ME) && (row_q == 2'd2) && (col_q == 2'd2);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (in_item_i.mode == MODE_READ) ? ST_RD_ADDR : ST_PREP;
        end
      end
      ST_PREP:  state_d = ST_SQR;
      ST_SQR:   state_d = ST_DEN;
      ST_DEN:   state_d = ST_DIV;
      ST_DIV: begin
        if (div_cnt_q == 6'(DIV_STEPS - 1)) begin
          state_d = ST_FIN1;
        end
      end
      ST_FIN1:  state_d = ST_FIN2;
      ST_FIN2:  state_d = ST_ACC;
      ST_ACC: begin
        if (acc_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!(s1_v_q || s2_v_q || s3_v_q || s4_v_q)) begin
          state_d = ST_IDLE;
        end
      end
      ST_RD_ADDR: state_d = ST_RD_DATA;
      ST_RD_DATA: begin
        if (rd_load) begin
          state_d = rd_last ? ST_IDLE : ST_RD_ADDR;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall_o    = (state_q != ST_IDLE);
    div_ctrl.load = (state_q == ST_DEN);
    div_ctrl.step = (state_q == ST_DIV);
    acc_issue     = (state_q == ST_ACC);
    rd_load       = (state_q == ST_RD_DATA) && (!out_valid_q || !out_stall_i);
  end

  assign adv = acc_issue || rd_load;

  // Counter order: part fastest while accumulating, then column, row and kind.
  always_comb begin
    part_d = part_q;
    col_d  = col_q;
    row_d  = row_q;
    kind_d = kind_q;
    if (adv) begin
      if (acc_issue && !part_q) begin
        part_d = 1'b1;
      end else begin
        part_d = 1'b0;
        if (col_q == 2'd2) begin
          col_d = 2'd0;
          if (row_q == 2'd2) begin
            row_d  = 2'd0;
            kind_d = kind_q + 2'd1;
          end else begin
            row_d = row_q + 2'd1;
          end
        end else begin
          col_d = col_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      part_q    <= 1'b0;
      col_q     <= 2'd0;
      row_q     <= 2'd0;
      kind_q    <= KIND_EE;
      div_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      part_q  <= part_d;
      col_q   <= col_d;
      row_q   <= row_d;
      kind_q  <= kind_d;
      if (div_ctrl.step) begin
        div_cnt_q <= div_cnt_q + 6'd1;
      end else begin
        div_cnt_q <= '0;
      end
    end
  end

  // Item capture and reciprocal setup
  logic signed [HALF_W:0] d1, d2;
  assign d1 = $signed({energy_q[FIELD_W-1], energy_q}) - $signed({2'b00, probe_q});
  assign d2 = $signed({energy_q[FIELD_W-1], energy_q}) + $signed({2'b00, probe_q});

  always_ff @(posedge clk_i) begin
    if (accept) begin
      energy_q    <= in_item_i.energy;
      el_raw_q[0] <= in_item_i.el_x;
      el_raw_q[1] <= in_item_i.el_y;
      el_raw_q[2] <= in_item_i.el_z;
      mg_raw_q[0] <= in_item_i.mag_x;
      mg_raw_q[1] <= in_item_i.mag_y;
      mg_raw_q[2] <= in_item_i.mag_z;
    end
    if (state_q == ST_PREP) begin
      for (int n = 0; n < 3; n++) begin
        el_mag_q[n] <= el_raw_q[n][FIELD_W-1] ? 32'(-el_raw_q[n]) : el_raw_q[n];
        el_neg_q[n] <= el_raw_q[n][FIELD_W-1];
        mg_mag_q[n] <= mg_raw_q[n][FIELD_W-1] ? 32'(-mg_raw_q[n]) : mg_raw_q[n];
        mg_neg_q[n] <= mg_raw_q[n][FIELD_W-1];
      end
      h1_q     <= d1[HALF_W] ? HALF_W'(-d1) : d1[HALF_W-1:0];
      h2_q     <= d2[HALF_W] ? HALF_W'(-d2) : d2[HALF_W-1:0];
      x1_neg_q <= d1[HALF_W];
      x2_neg_q <= d2[HALF_W];
    end
    if (state_q == ST_SQR) begin
      sq1_q <= h1_q * h1_q;
      sq2_q <= h2_q * h2_q;
      gg_q  <= damp_q * damp_q;
    end
    if (state_q == ST_DEN) begin
      den1_q  <= {1'b0, sq1_q, 2'b00} + {5'b00000, gg_q};
      den2_q  <= {1'b0, sq2_q, 2'b00} + {5'b00000, gg_q};
      zero1_q <= (h1_q == '0) && (damp_q == '0);
      zero2_q <= (h2_q == '0) && (damp_q == '0);
    end
  end

  // Four divider lanes: real and imaginary parts of both reciprocals.
  sos_recip_div u_div_r1r (
    .clk_i (clk_i), .ctrl_i (div_ctrl), .num_i ({h1_q, 1'b0}), .den_i (den1_q),
    .quot_o (quot[0])
  );
  sos_recip_div u_div_r1i (
    .clk_i (clk_i), .ctrl_i (div_ctrl), .num_i ({2'b00, damp_q}), .den_i (den1_q),
    .quot_o (quot[1])
  );
  sos_recip_div u_div_r2r (
    .clk_i (clk_i), .ctrl_i (div_ctrl), .num_i ({h2_q, 1'b0}), .den_i (den2_q),
    .quot_o (quot[2])
  );
  sos_recip_div u_div_r2i (
    .clk_i (clk_i), .ctrl_i (div_ctrl), .num_i ({2'b00, damp_q}), .den_i (den2_q),
    .quot_o (quot[3])
  );

  // Sign the quotients, then form sums and differences as magnitude and sign.
  logic signed [R_W-1:0]   q0s, q1s, q2s, q3s;
  logic signed [SUM_W-1:0] sums [4];

  assign q0s = $signed({1'b0, quot[0]});
  assign q1s = $signed({1'b0, quot[1]});
  assign q2s = $signed({1'b0, quot[2]});
  assign q3s = $signed({1'b0, quot[3]});

  assign sums[SLOT_SR] = {r1r_q[R_W-1], r1r_q} + {r2r_q[R_W-1], r2r_q};
  assign sums[SLOT_SI] = {r1i_q[R_W-1], r1i_q} + {r2i_q[R_W-1], r2i_q};
  assign sums[SLOT_DR] = {r1r_q[R_W-1], r1r_q} - {r2r_q[R_W-1], r2r_q};
  assign sums[SLOT_DI] = {r1i_q[R_W-1], r1i_q} - {r2i_q[R_W-1], r2i_q};

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN1) begin
      r1r_q <= zero1_q ? RECIP_SAT : (x1_neg_q ? -q0s : q0s);
      r1i_q <= zero1_q ? '0 : q1s;
      r2r_q <= zero2_q ? RECIP_SAT : (x2_neg_q ? -q2s : q2s);
      r2i_q <= zero2_q ? '0 : -q3s;
    end
    if (state_q == ST_FIN2) begin
      for (int n = 0; n < 4; n++) begin
        s_mag_q[n] <= sums[n][SUM_W-1] ? S_W'(-sums[n]) : sums[n][S_W-1:0];
        s_neg_q[n] <= sums[n][SUM_W-1];
      end
    end
  end

  // Operand selection for the entry being issued
  logic [FIELD_W-1:0] el_row_mag, mg_row_mag, el_col_mag, mg_col_mag;
  logic               el_row_neg, mg_row_neg, el_col_neg, mg_col_neg;
  logic [FIELD_W-1:0] a_mag, b_mag;
  logic               a_neg, b_neg;
  logic [1:0]         s_slot;
  logic               negate;
  logic [2*FIELD_W-1:0] p_full;

  always_comb begin
    case (row_q)
      2'd0: begin
        el_row_mag = el_mag_q[0]; el_row_neg = el_neg_q[0];
        mg_row_mag = mg_mag_q[0]; mg_row_neg = mg_neg_q[0];
      end
      2'd1: begin
        el_row_mag = el_mag_q[1]; el_row_neg = el_neg_q[1];
        mg_row_mag = mg_mag_q[1]; mg_row_neg = mg_neg_q[1];
      end
      default: begin
        el_row_mag = el_mag_q[2]; el_row_neg = el_neg_q[2];
        mg_row_mag = mg_mag_q[2]; mg_row_neg = mg_neg_q[2];
      end
    endcase
    case (col_q)
      2'd0: begin
        el_col_mag = el_mag_q[0]; el_col_neg = el_neg_q[0];
        mg_col_mag = mg_mag_q[0]; mg_col_neg = mg_neg_q[0];
      end
      2'd1: begin
        el_col_mag = el_mag_q[1]; el_col_neg = el_neg_q[1];
        mg_col_mag = mg_mag_q[1]; mg_col_neg = mg_neg_q[1];
      end
      default: begin
        el_col_mag = el_mag_q[2]; el_col_neg = el_neg_q[2];
        mg_col_mag = mg_mag_q[2]; mg_col_neg = mg_neg_q[2];
      end
    endcase
  end

  always_comb begin
    case (kind_q)
      KIND_EE: begin
        a_mag = el_row_mag; a_neg = el_row_neg; b_mag = el_col_mag; b_neg = el_col_neg;
        s_slot = part_q ? SLOT_SI : SLOT_SR; negate = 1'b0;
      end
      KIND_MM: begin
        a_mag = mg_row_mag; a_neg = mg_row_neg; b_mag = mg_col_mag; b_neg = mg_col_neg;
        s_slot = part_q ? SLOT_SI : SLOT_SR; negate = 1'b0;
      end
      KIND_EM: begin
        a_mag = el_row_mag; a_neg = el_row_neg; b_mag = mg_col_mag; b_neg = mg_col_neg;
        s_slot = part_q ? SLOT_DR : SLOT_DI; negate = part_q;
      end
      default: begin
        a_mag = mg_row_mag; a_neg = mg_row_neg; b_mag = el_col_mag; b_neg = el_col_neg;
        s_slot = part_q ? SLOT_DR : SLOT_DI; negate = !part_q;
      end
    endcase
  end

  assign p_full = a_mag * b_mag;

  // Scaling pipeline: dipole product, partial products, their sum, then shift and clamp.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      s1_v_q <= acc_issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  logic [ACC_W-1:0]        m_mag;
  logic signed [ACC_W-1:0] s3_val;

  always_comb begin
    m_mag = (s3_w_q[W_W-1:104] != '0) ? '1 : s3_w_q[103:40];
    if (m_mag == '0) begin
      s3_val = '0;
    end else if (s3_neg_q) begin
      s3_val = m_mag[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : -$signed(m_mag);
    end else begin
      s3_val = m_mag[ACC_W-1] ? {1'b0, {(ACC_W-1){1'b1}}} : $signed(m_mag);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_p_q    <= p_full[P_W-1:0];
    s1_s_q    <= s_mag_q[s_slot];
    s1_neg_q  <= a_neg ^ b_neg ^ s_neg_q[s_slot] ^ negate;
    s1_k_q    <= k_cnt;
    s1_part_q <= part_q;

    pp00_q    <= s1_p_q[31:0]  * s1_s_q[27:0];
    pp01_q    <= s1_p_q[31:0]  * s1_s_q[S_W-1:28];
    pp10_q    <= s1_p_q[P_W-1:32] * s1_s_q[27:0];
    pp11_q    <= s1_p_q[P_W-1:32] * s1_s_q[S_W-1:28];
    s2_neg_q  <= s1_neg_q;
    s2_k_q    <= s1_k_q;
    s2_part_q <= s1_part_q;

    s3_w_q    <= {58'd0, pp00_q} + ({59'd0, pp01_q} << 28)
               + ({59'd0, pp10_q} << 32) + ({60'd0, pp11_q} << 60);
    s3_neg_q  <= s2_neg_q;
    s3_k_q    <= s2_k_q;
    s3_part_q <= s2_part_q;

    s4_val_q  <= s3_val;
    s4_k_q    <= s3_k_q;
    s4_part_q <= s3_part_q;
  end

  // Accumulator read port: readout address while reading out, else the scaling stage 3 entry.
  assign rd_addr = ((state_q == ST_RD_ADDR) || (state_q == ST_RD_DATA)) ? k_cnt : s3_k_q;

  logic signed [ACC_W-1:0] old_val, new_val;
  assign old_val = s4_part_q ? (rd_vim_q ? rd_im_q : '0) : (rd_vre_q ? rd_re_q : '0);
  assign new_val = sat_add(old_val, s4_val_q);

  always_ff @(posedge clk_i) begin
    rd_re_q  <= acc_re_mem[rd_addr];
    rd_im_q  <= acc_im_mem[rd_addr];
    rd_vre_q <= vld_re_q[rd_addr];
    rd_vim_q <= vld_im_q[rd_addr];
    if (s4_v_q && !s4_part_q) begin
      acc_re_mem[s4_k_q] <= new_val;
    end
    if (s4_v_q && s4_part_q) begin
      acc_im_mem[s4_k_q] <= new_val;
    end
  end

  // Valid bits: set by an update, cleared as the entry is read out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_re_q <= '0;
      vld_im_q <= '0;
    end else begin
      if (s4_v_q && !s4_part_q) begin
        vld_re_q[s4_k_q] <= 1'b1;
      end
      if (s4_v_q && s4_part_q) begin
        vld_im_q[s4_k_q] <= 1'b1;
      end
      if (rd_load) begin
        vld_re_q[k_cnt] <= 1'b0;
        vld_im_q[k_cnt] <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= rd_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_load) begin
      out_q.tensor_kind <= kind_q;
      out_q.row         <= row_q;
      out_q.column      <= col_q;
      out_q.real_part   <= rd_vre_q ? rd_re_q : '0;
      out_q.imag_part   <= rd_vim_q ? rd_im_q : '0;
      out_q.last        <= rd_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- hw/rtl/sos_checker.sv -----
// Port-level checks of the tensor unit and their attachment to the top level.
module sos_checker import sos_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input in_item_t    in_item_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_item_t   out_item_o
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // After a readout transaction is taken, the input is stalled.
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.mode == MODE_READ |=> in_stall_o)
    else $error("input not stalled during readout");

  // Row and column stay within the tensor.
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.row != 2'd3 && out_item_o.column != 2'd3)
    else $error("row or column out of range");

  // The last flag marks only the final magnetic-electric corner entry.
  a_last_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.last |->
      out_item_o.tensor_kind == KIND_ME && out_item_o.row == 2'd2 && out_item_o.column == 2'd2)
    else $error("last flag on a wrong entry");

endmodule

bind sum_over_states_response_tensor_unit sos_checker u_sos_checker (.*);

// ----- test/tb_sum_over_states_response_tensor_unit.sv -----
// Testbench for the sum-over-states response tensor unit: directed and random states.
module tb_sum_over_states_response_tensor_unit;
  import sos_pkg::*;

  // Wide helpers for the tensor update prediction.
  function automatic logic signed [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  // Complex reciprocal of (x + i*y) in Q.21 units; parts in signed Q.53.
  function automatic void reciprocal(input logic signed [63:0] x, input logic signed [63:0] y,
                                     output logic signed [63:0] re,
                                     output logic signed [63:0] im);
    logic [127:0] den;
    logic [127:0] xm;
    logic [127:0] ym;
    logic [127:0] qr;
    logic [127:0] qi;
    if (x == 0 && y == 0) begin
      re = 64'sd1 <<< 53;
      im = 0;
      return;
    end
    xm = (x < 0) ? -x : x;
    ym = (y < 0) ? -y : y;
    den = xm * xm + ym * ym;
    qr = (xm << 53) / den;
    qi = (ym << 53) / den;
    re = (x < 0) ? -$signed(qr[63:0]) : $signed(qr[63:0]);
    im = (y < 0) ? $signed(qi[63:0]) : -$signed(qi[63:0]);
  endfunction

  // Dipole product times reciprocal term, shifted by 40 toward zero and clamped.
  function automatic logic signed [63:0] scaled_term(input logic signed [63:0] p,
                                                     input logic signed [63:0] s,
                                                     input bit negate);
    logic [127:0] w;
    logic [127:0] m;
    bit neg;
    neg = ((p < 0) != (s < 0)) ^ negate;
    w = 128'(p < 0 ? -p : p) * 128'(s < 0 ? -s : s);
    m = w >> 40;
    if (m == 0) return 0;
    if (neg) return (m >= (128'd1 << 63)) ? 64'sh8000000000000000 : -$signed(m[63:0]);
    return (m > 128'h7FFFFFFFFFFFFFFF) ? 64'sh7FFFFFFFFFFFFFFF : $signed(m[63:0]);
  endfunction

  function automatic logic signed [63:0] clamp_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
    return s[63:0];
  endfunction

  // Tensor sums and the queue of entries a readout must produce.
  class tensor_scoreboard;
    logic [30:0] omega;
    logic [30:0] gamma;
    logic signed [63:0] sum_re[NUM_ENTRIES];
    logic signed [63:0] sum_im[NUM_ENTRIES];
    out_item_t pending_entries[$];
    int errors;

    function new();
      omega = 0;
      gamma = 0;
      errors = 0;
      foreach (sum_re[k]) begin
        sum_re[k] = 0;
        sum_im[k] = 0;
      end
    endfunction

    function void add_entry(int k, logic signed [63:0] re, logic signed [63:0] im);
      sum_re[k] = clamp_add(sum_re[k], re);
      sum_im[k] = clamp_add(sum_im[k], im);
    endfunction

    function void note_state(in_item_t it);
      logic signed [63:0] e[3];
      logic signed [63:0] m[3];
      logic signed [63:0] en;
      logic signed [63:0] r1r, r1i, r2r, r2i, sr, si, dr, di;
      logic signed [63:0] pee, pmm, pem, pme;
      out_item_t o;
      int c;
      if (it.mode == MODE_READ) begin
        for (int k = 0; k < NUM_ENTRIES; k++) begin
          o.tensor_kind = 2'(k / 9);
          o.row = 2'((k / 3) % 3);
          o.column = 2'(k % 3);
          o.real_part = sum_re[k];
          o.imag_part = sum_im[k];
          o.last = (k == NUM_ENTRIES - 1);
          pending_entries.push_back(o);
          sum_re[k] = 0;
          sum_im[k] = 0;
        end
        return;
      end
      en = sx32(it.energy);
      e[0] = sx32(it.el_x); e[1] = sx32(it.el_y); e[2] = sx32(it.el_z);
      m[0] = sx32(it.mag_x); m[1] = sx32(it.mag_y); m[2] = sx32(it.mag_z);
      reciprocal(2 * (en - omega), -$signed({33'd0, gamma}), r1r, r1i);
      reciprocal(2 * (en + omega), $signed({33'd0, gamma}), r2r, r2i);
      sr = r1r + r2r; si = r1i + r2i; dr = r1r - r2r; di = r1i - r2i;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          c = i * 3 + j;
          pee = e[i] * e[j]; pmm = m[i] * m[j]; pem = e[i] * m[j]; pme = m[i] * e[j];
          add_entry(c, scaled_term(pee, sr, 0), scaled_term(pee, si, 0));
          add_entry(9 + c, scaled_term(pmm, sr, 0), scaled_term(pmm, si, 0));
          add_entry(18 + c, scaled_term(pem, di, 0), scaled_term(pem, dr, 1));
          add_entry(27 + c, scaled_term(pme, di, 1), scaled_term(pme, dr, 0));
        end
      end
    endfunction

    function void check_entry(out_item_t got);
      out_item_t exp_e;
      if (pending_entries.size() == 0) begin
        $display("%0t: unexpected entry %p", $time, got);
        errors++;
        return;
      end
      exp_e = pending_entries.pop_front();
      if (got.tensor_kind !== exp_e.tensor_kind || got.row !== exp_e.row ||
          got.column !== exp_e.column || got.last !== exp_e.last) begin
        $display("%0t: index expected %0d/%0d/%0d last %0d, got %0d/%0d/%0d last %0d", $time,
                 exp_e.tensor_kind, exp_e.row, exp_e.column, exp_e.last,
                 got.tensor_kind, got.row, got.column, got.last);
        errors++;
      end
      if (got.real_part !== exp_e.real_part) begin
        $display("%0t: real expected %0d, got %0d", $time, exp_e.real_part, got.real_part);
        errors++;
      end
      if (got.imag_part !== exp_e.imag_part) begin
        $display("%0t: imag expected %0d, got %0d", $time, exp_e.imag_part, got.imag_part);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  out_item_t out_item_o;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;

  tensor_scoreboard tensors = new();
  int hold_cycles = 0;
  bit stall_noise = 1;

  sum_over_states_response_tensor_unit i_dut (.*);

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  // Check results and note accepted states at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tensors.check_entry(out_item_o);
    if (rst_ni && in_valid_i && !in_stall_o) tensors.note_state(in_item_i);
  end

  // Receiver stall pattern, with forced long holds.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1;
    end else begin
      out_stall_i <= stall_noise && ($urandom_range(0, 3) == 0);
    end
  end

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk_i);
    psel <= 1; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= value; penable <= 0;
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (idx == REG_PROBE) tensors.omega = value[30:0];
    else tensors.gamma = value[30:0];
  endtask

  // Offer one state; valid stays high until accepted.
  task automatic send_state(input in_item_t it, input bit keep_valid);
    @(negedge clk_i);
    in_item_i <= it;
    in_valid_i <= 1;
    do @(posedge clk_i); while (in_stall_o);
    if (!keep_valid) begin
      @(negedge clk_i);
      in_valid_i <= 0;
    end
  endtask

  task automatic wait_drained();
    while (tensors.pending_entries.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_field(input int sel);
    case (sel)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t make_state(input int sel);
    in_item_t it;
    it.mode = MODE_ACC;
    it.energy = (sel == 2) ? 32'($signed($urandom_range(0, 1 << 24))) : rand_field(sel);
    it.el_x = rand_field(sel); it.el_y = rand_field(sel); it.el_z = rand_field(sel);
    it.mag_x = rand_field(sel); it.mag_y = rand_field(sel); it.mag_z = rand_field(sel);
    return it;
  endfunction

  function automatic in_item_t make_readout();
    in_item_t it;
    it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b1};
    it.mode = MODE_READ;
    return it;
  endfunction

  // The last state of each burst drops valid, so a gap starts with valid low.
  task automatic run_phase(input int states);
    int burst;
    burst = 0;
    for (int n = 0; n < states; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 8);
        repeat ($urandom_range(0, 5)) @(negedge clk_i);
      end
      burst--;
      if ($urandom_range(0, 9) == 0)
        send_state(make_readout(), burst != 0);
      else
        send_state(make_state($urandom_range(0, 4) == 0 ? $urandom_range(0, 1) :
                              $urandom_range(2, 3)), burst != 0);
    end
    send_state(make_readout(), 0);
  endtask

  initial begin
    in_item_t it;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // Directed: reset registers with a zero denominator, then field extremes.
    it = '0;
    send_state(it, 0);
    it.energy = 0; it.el_x = 32'h7FFF_FFFF; it.mag_z = 32'h8000_0000;
    send_state(it, 0);
    it = {1'b0, {7{32'h8000_0000}}};
    send_state(it, 0);
    it = {1'b0, {7{32'h7FFF_FFFF}}};
    send_state(it, 0);
    send_state(make_readout(), 0);
    wait_drained();
    write_reg(REG_PROBE, 32'hFFFF_FFFF);
    write_reg(REG_DAMP, 32'h7FFF_FFFF);
    for (int n = 0; n < 4; n++) send_state(make_state(n), 0);
    send_state(make_readout(), 0);
    wait_drained();
    // Energy equal to omega with no damping: first reciprocal saturates.
    write_reg(REG_PROBE, 32'h0010_0000);
    write_reg(REG_DAMP, 0);
    it = make_state(2);
    it.energy = 32'h0010_0000;
    send_state(it, 0);
    it.energy = 32'hFFF0_0000;
    send_state(it, 0);
    send_state(make_readout(), 0);
    send_state(make_readout(), 0);

    // Long receiver hold while states keep arriving.
    hold_cycles = 3000;
    run_phase(20);
    wait_drained();

    // Random phases over several register settings.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_PROBE, (ph % 3 == 0) ? $urandom_range(0, 1 << 22) : $urandom);
      write_reg(REG_DAMP, (ph % 4 == 1) ? 0 : (ph % 3 == 0 ? $urandom_range(0, 1 << 20) :
                                                $urandom));
      stall_noise = (ph != 3);
      run_phase(52);
      wait_drained();
    end

    if (tensors.errors == 0 && tensors.pending_entries.size() == 0)
      $display("sum_over_states_response_tensor_unit: match");
    else
      $display("sum_over_states_response_tensor_unit: mismatch");
    $finish;
  end

  initial begin
    #20000000;
    $display("sum_over_states_response_tensor_unit: mismatch");
    $finish;
  end
endmodule
